// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ppq_pkg.sv =====
`default_nettype none
package ppq_pkg;

  localparam int TRANSPARENT_INDEX_DEF = 0;
  localparam int PAL_ENTRIES           = 16;
  localparam int CFG_WIDTH             = 64;
  localparam logic [7:0] ALPHA_OPAQUE_MIN = 8'd128;

  typedef enum logic [0:0] {
    CFG_PAL_LOW  = 1'b0,
    CFG_PAL_HIGH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       first_in_row;
  } pix_t;

  // match result handed to the packer
  typedef struct packed {
    logic       valid;
    logic       first;
    logic [3:0] idx;
  } pk_in_t;

endpackage
`default_nettype wire

// ===== src/ppq_if.sv =====
`default_nettype none
interface ppq_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       first_in_row;

  modport source (output valid, output red, output green, output blue,
                  output alpha, output first_in_row, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, input first_in_row, output ready);
endinterface

interface ppq_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface
`default_nettype wire

// ===== src/ppq_match.sv =====
`default_nettype none
module ppq_match import ppq_pkg::*; #(
  parameter int TRANSPARENT_INDEX = TRANSPARENT_INDEX_DEF
) (
  input  wire pix_t         pix,
  input  wire logic [127:0] palette,
  output logic [3:0]        idx
);

  localparam logic [3:0] TrIdx = 4'(TRANSPARENT_INDEX % PAL_ENTRIES);

  typedef struct packed {
    logic [7:0] score;
    logic [3:0] idx;
  } cand_t;

  function automatic logic [5:0] sq_diff3(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] d;
    d = {3'b000, ((a > b) ? (a - b) : (b - a))};
    return d * d;
  endfunction

  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    return (hi.score < lo.score) ? hi : lo;
  endfunction

  logic [2:0] cr, cg, cb;
  cand_t      lvl0 [PAL_ENTRIES];
  cand_t      lvl1 [8];
  cand_t      lvl2 [4];
  cand_t      lvl3 [2];
  cand_t      best;

  assign cr = pix.red[7:5];
  assign cg = pix.green[7:5];
  assign cb = {1'b0, pix.blue[7:6]};

  always_comb begin
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      logic [7:0] p;
      p = palette[i*8 +: 8];
      lvl0[i].idx   = 4'(i);
      lvl0[i].score = 8'(sq_diff3(cr, p[7:5])) + 8'(sq_diff3(cg, p[4:2]))
                    + 8'(sq_diff3(cb, {1'b0, p[1:0]}));
      // transparent slot never wins: real distances stay below 108
      if (4'(i) == TrIdx) begin
        lvl0[i].score = 8'hff;
      end
    end
    for (int i = 0; i < 8; i++) lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
    for (int i = 0; i < 4; i++) lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    for (int i = 0; i < 2; i++) lvl3[i] = pick(lvl2[2*i], lvl2[2*i+1]);
    best = pick(lvl3[0], lvl3[1]);
  end

  assign idx = (pix.alpha < ALPHA_OPAQUE_MIN) ? TrIdx : best.idx;

endmodule
`default_nettype wire

// ===== src/ppq_pack.sv =====
`default_nettype none
`include "assert_macros.svh"
module ppq_pack import ppq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire pk_in_t pk_in,
  output logic        take,
  ppq_byte_if.source  out_byte
);

  logic       odd_r, odd_nxt;
  logic [3:0] held_r, held_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       odd_eff, emit, out_free;

  assign odd_eff  = odd_r & ~pk_in.first;
  assign emit     = odd_eff;
  assign out_free = ~out_valid_r | out_byte.ready;
  assign take     = pk_in.valid & (~emit | out_free);

  always_comb begin
    odd_nxt       = odd_r;
    held_nxt      = held_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r & ~out_byte.ready;
    if (take) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        byte_nxt      = {held_r, pk_in.idx};
        odd_nxt       = 1'b0;
      end else begin
        held_nxt = pk_in.idx;
        odd_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r       <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      odd_r       <= odd_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign out_byte.valid       = out_valid_r;
  assign out_byte.packed_byte = byte_r;

  `ASSERT_NEXT(a_emit_byte, take && emit, out_valid_r && byte_r[3:0] == $past(pk_in.idx))
  `ASSERT_NEXT(a_hold_nibble, take && !emit, odd_r && held_r == $past(pk_in.idx))
  `ASSERT_NOW(a_first_even, take && pk_in.first, !emit)

endmodule
`default_nettype wire

// ===== src/palette_quantize_pack_4bit.sv =====
// Path: an accepted pixel is registered, matched, then its byte is registered at the output.
// Throughput: one pixel per cycle unless a byte output stall holds it; the match is one pass
// over all 16 entries between the input register and the packing stage, and an output register
// lets a new pixel in while a finished byte waits.
// Reset: synchronous, active low; clears both palette words, valid flags, nibble parity and held index.
`default_nettype none
`include "assert_macros.svh"
module palette_quantize_pack_4bit import ppq_pkg::*; #(
  parameter int TRANSPARENT_INDEX = TRANSPARENT_INDEX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data,
  ppq_pix_if.sink                   in_pix,
  ppq_byte_if.source                out_byte
);

  localparam logic [3:0] TrIdx = 4'(TRANSPARENT_INDEX % PAL_ENTRIES);

  logic [CFG_WIDTH-1:0] pal_low_r, pal_high_r;
  pix_t                 pix_r, pix_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 in_acc, take;
  logic [3:0]           mt_idx;
  pk_in_t               pk_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_low_r  <= '0;
      pal_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAL_LOW:  pal_low_r  <= cfg_data;
        CFG_PAL_HIGH: pal_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_pix.ready = ~s1_valid_r | take;
  assign in_acc       = in_pix.valid & in_pix.ready;

  always_comb begin
    pix_nxt      = pix_r;
    s1_valid_nxt = s1_valid_r & ~take;
    if (in_acc) begin
      pix_nxt.red          = in_pix.red;
      pix_nxt.green        = in_pix.green;
      pix_nxt.blue         = in_pix.blue;
      pix_nxt.alpha        = in_pix.alpha;
      pix_nxt.first_in_row = in_pix.first_in_row;
      s1_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    pix_r <= pix_nxt;
  end

  ppq_match #(
    .TRANSPARENT_INDEX(TRANSPARENT_INDEX)
  ) u_match (
    .pix     (pix_r),
    .palette ({pal_high_r, pal_low_r}),
    .idx     (mt_idx)
  );

  assign pk_in.valid = s1_valid_r;
  assign pk_in.first = pix_r.first_in_row;
  assign pk_in.idx   = mt_idx;

  ppq_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .pk_in    (pk_in),
    .take     (take),
    .out_byte (out_byte)
  );

  `ASSERT_NOW(a_transparent, s1_valid_r && pix_r.alpha < ALPHA_OPAQUE_MIN, mt_idx == TrIdx)
  `ASSERT_NOW(a_opaque_skip, s1_valid_r && pix_r.alpha >= ALPHA_OPAQUE_MIN, mt_idx != TrIdx)
  `ASSERT_NEXT(a_stage_load, in_acc, s1_valid_r)

endmodule
`default_nettype wire

// ===== bench/ppq_checker.sv =====
module ppq_checker import ppq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  ppq_pix_if                   pix,
  ppq_byte_if                  byte_ch,
  output int                   n_fail,
  output int                   n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] TRANS_IDX = 4'(TRANSPARENT_INDEX_DEF % 16);

  logic [CFG_WIDTH-1:0] pal_lo;
  logic [CFG_WIDTH-1:0] pal_hi;
  logic                 odd_slot;
  logic [3:0]           high_nibble;
  logic [7:0]           bytes_due[$];
  int                   fails;

  assign n_fail = fails;

  // RGB332 cut, then first palette entry at least distance, transparent slot skipped
  function automatic logic [3:0] nearest_index(input logic [7:0] r, g, b);
    logic [7:0] p;
    logic [3:0] best;
    int dr, dg, db, d, best_d;
    best = 4'd0;
    best_d = 1000;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      if (i != int'(TRANS_IDX)) begin
        p = (i < 8) ? pal_lo[i*8 +: 8] : pal_hi[(i-8)*8 +: 8];
        dr = int'(r[7:5]) - int'(p[7:5]);
        dg = int'(g[7:5]) - int'(p[4:2]);
        db = int'(b[7:6]) - int'(p[1:0]);
        d = dr*dr + dg*dg + db*db;
        if (d < best_d) begin
          best_d = d;
          best = i[3:0];
        end
      end
    end
    return best;
  endfunction

  task automatic report_bad(input string msg);
    $display("ppq_checker: %s", msg);
    fails++;
  endtask

  always @(posedge clk) begin
    logic [3:0] idx;
    logic [7:0] want;
    if (!rst_n) begin
      pal_lo = '0;
      pal_hi = '0;
      odd_slot = 1'b0;
      high_nibble = 4'd0;
      fails = 0;
      bytes_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PAL_LOW) pal_lo = cfg_data;
        else pal_hi = cfg_data;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        if (bytes_due.size() == 0) begin
          report_bad($sformatf("unexpected word %h", byte_ch.packed_byte));
        end else begin
          want = bytes_due.pop_front();
          if (byte_ch.packed_byte !== want)
            report_bad($sformatf("packed_byte got %h expected %h",
                                 byte_ch.packed_byte, want));
        end
      end
      if (pix.valid && pix.ready) begin
        if (pix.first_in_row) odd_slot = 1'b0;
        if (pix.alpha < ALPHA_OPAQUE_MIN) idx = TRANS_IDX;
        else idx = nearest_index(pix.red, pix.green, pix.blue);
        if (!odd_slot) begin
          high_nibble = idx;
          odd_slot = 1'b1;
        end else begin
          bytes_due.push_back({high_nibble, idx});
          odd_slot = 1'b0;
        end
      end
    end
    n_pending <= bytes_due.size();
  end

endmodule

// ===== bench/palette_quantize_pack_4bit_tb.sv =====
module palette_quantize_pack_4bit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppq_pkg::*;

  localparam int LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [0:0]           cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  int                   n_fail;
  int                   n_pending;
  logic                 hold_req;
  logic [1:0]           rx_mode;
  int                   burst_left;
  bit                   gaps_on;
  logic [CFG_WIDTH-1:0] cur_lo;
  logic [CFG_WIDTH-1:0] cur_hi;
  logic [CFG_WIDTH-1:0] rnd_pal;
  int                   sent;

  ppq_pix_if  pix_ch();
  ppq_byte_if byte_ch();

  palette_quantize_pack_4bit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_pix   (pix_ch),
    .out_byte (byte_ch)
  );

  ppq_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix_ch),
    .byte_ch  (byte_ch),
    .n_fail   (n_fail),
    .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: stall pattern per mode, long hold each time hold_req toggles
  initial begin
    int hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req !== hold_seen) begin
        hold_left = 80;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          2'd0: byte_ch.ready <= 1'b1;
          2'd1: byte_ch.ready <= ($urandom_range(0, 1) == 1);
          default: byte_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_pix(input logic [7:0] r, g, b, a, input logic first);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        pix_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red <= r;
    pix_ch.green <= g;
    pix_ch.blue <= b;
    pix_ch.alpha <= a;
    pix_ch.first_in_row <= first;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_rand_pixel(input logic first);
    logic [7:0] r, g, b, a, p;
    int e;
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    // a quarter of pixels hit a palette color exactly
    if ($urandom_range(0, 3) == 0) begin
      e = $urandom_range(0, 15);
      p = (e < 8) ? cur_lo[e*8 +: 8] : cur_hi[(e-8)*8 +: 8];
      r[7:5] = p[7:5];
      g[7:5] = p[4:2];
      b[7:6] = p[1:0];
    end
    case ($urandom_range(0, 2))
      0: a = $urandom_range(0, 255);
      1: a = $urandom_range(124, 131);
      default: a = $urandom_range(128, 255);
    endcase
    send_pix(r, g, b, a, first);
  endtask

  // rows of random width; occasional missing or stray row marks
  task automatic random_phase(input int n);
    int stop_at, width;
    logic first;
    stop_at = sent + n;
    while (sent < stop_at) begin
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
      for (int i = 0; i < width; i++) begin
        if (i == 0) first = ($urandom_range(0, 11) != 0);
        else first = ($urandom_range(0, 24) == 0);
        send_rand_pixel(first);
      end
    end
  endtask

  task automatic drain_bytes();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_palette(input logic [CFG_WIDTH-1:0] lo, hi);
    cur_lo = lo;
    cur_hi = hi;
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAL_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_PAL_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // palette here is entry i = i * 0x11
  task automatic directed_pixels();
    send_pix(8'h00, 8'h00, 8'h00, 8'hff, 1'b1);  // matches transparent slot only
    send_pix(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_pix(8'h80, 8'h40, 8'h20, 8'd127, 1'b1); // just below opaque
    send_pix(8'h40, 8'ha0, 8'h40, 8'd128, 1'b0); // exact entry 5, just opaque
    send_pix(8'hff, 8'h00, 8'hff, 8'h00, 1'b0);
    send_pix(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
    send_pix(8'h40, 8'ha0, 8'h80, 8'hff, 1'b0);  // near miss
    send_pix(8'h1f, 8'h1f, 8'h3f, 8'hff, 1'b0);
    // odd width row: trailing nibble dropped at next mark
    send_pix(8'hc0, 8'h20, 8'h40, 8'hff, 1'b1);
    send_pix(8'h20, 8'hc0, 8'h80, 8'hff, 1'b0);
    send_pix(8'he0, 8'he0, 8'hc0, 8'hff, 1'b0);
    send_pix(8'h60, 8'h60, 8'h40, 8'hff, 1'b1);
    send_pix(8'ha0, 8'h40, 8'hc0, 8'hff, 1'b0);
    // no row mark: parity keeps going
    send_pix(8'h33, 8'h77, 8'hbb, 8'h80, 1'b0);
    send_pix(8'hcc, 8'h88, 8'h44, 8'h7f, 1'b0);
    send_pix(8'h99, 8'h55, 8'h11, 8'hfe, 1'b0);
    send_pix(8'hff, 8'hff, 8'hff, 8'd128, 1'b1);
    send_pix(8'h00, 8'h00, 8'h00, 8'd127, 1'b0);
    send_pix(8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
    send_pix(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PAL_LOW;
    cfg_data <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.red <= 8'h00;
    pix_ch.green <= 8'h00;
    pix_ch.blue <= 8'h00;
    pix_ch.alpha <= 8'h00;
    pix_ch.first_in_row <= 1'b0;
    hold_req <= 1'b0;
    rx_mode <= 2'd1;
    burst_left = 0;
    gaps_on = 1'b1;
    cur_lo = '0;
    cur_hi = '0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_phase(40);
    drain_bytes();
    write_palette(64'h7766554433221100, 64'hffeeddccbbaa9988);
    directed_pixels();
    random_phase(100);

    drain_bytes();
    write_palette('1, '1);
    gaps_on = 1'b0;
    rx_mode <= 2'd0;
    random_phase(100);

    drain_bytes();
    write_palette('0, '0);
    gaps_on = 1'b1;
    rx_mode <= 2'd2;
    random_phase(80);

    // duplicate halves: ties go to the low half
    drain_bytes();
    rnd_pal = {$urandom, $urandom};
    write_palette(rnd_pal, rnd_pal);
    rx_mode <= 2'd1;
    hold_req <= ~hold_req;
    random_phase(60);
    drain_bytes();
    hold_req <= ~hold_req;
    random_phase(60);

    drain_bytes();
    write_palette({$urandom, $urandom}, {$urandom, $urandom});
    random_phase(120);

    drain_bytes();
    write_palette({$urandom, $urandom}, {$urandom, $urandom});
    rx_mode <= 2'd2;
    random_phase(100);

    drain_bytes();
    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ppq_pkg.sv
src/ppq_if.sv
src/ppq_match.sv
src/ppq_pack.sv
src/palette_quantize_pack_4bit.sv
bench/ppq_checker.sv
bench/palette_quantize_pack_4bit_tb.sv
